FILE: hdl/gpd_pkg.sv
// Shared types, codes and constants for the gossip packet decoder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package gpd_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  // Header positions of each packet layout
  localparam logic [3:0] IdLastPos      = 4'd7;
  localparam logic [3:0] DataIdEndPos   = 4'd8;
  localparam logic [3:0] DataPayloadPos = 4'd12;
  localparam logic [3:0] GossipIdPos    = 4'd2;
  localparam logic [3:0] GossipIdLast   = 4'd9;
  localparam logic [3:0] SingleDonePos  = 4'd8;

  localparam logic [7:0] TypeFirst = 8'd1;
  localparam logic [7:0] TypeLast  = 8'd4;

  typedef enum logic [2:0] {
    KIND_MSG_ID    = 3'd0,
    KIND_PEER_ID   = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_GOSSIP_ID = 3'd3,
    KIND_END       = 3'd4
  } item_kind_e;

  typedef enum logic [1:0] {
    PK_DATA      = 2'd0,
    PK_GOSSIP    = 2'd1,
    PK_REQUEST   = 2'd2,
    PK_HEARTBEAT = 2'd3
  } pkt_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_TRAIL   = 2'd3
  } status_e;

  typedef struct packed {
    item_kind_e  item_kind;
    logic [63:0] item_value;
    pkt_kind_e   packet_kind;
    status_e     status;
    logic        final_res;
  } gpd_result_t;

  // True once the packet's layout has been consumed in full
  function automatic logic structure_complete(pkt_kind_e kind, logic [3:0] pos,
                                              logic [31:0] rem);
    logic done;
    unique case (kind)
      PK_DATA:   done = (pos == DataPayloadPos) && (rem == 32'd0);
      PK_GOSSIP: done = (pos == GossipIdPos) && (rem == 32'd0);
      default:   done = (pos == SingleDonePos);
    endcase
    return done;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gpd_front.sv
// Front end: accepts packet bytes, tracks the packet layout and builds results.
// Depends on gpd_pkg; pushes results into gpd_queue.
`timescale 1ns / 1ps
`default_nettype none

module gpd_front import gpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_packet_i,
  input  wire logic        full_i,
  output logic             push_o,
  output gpd_result_t      result_o
);

  logic        start_q, start_d;
  pkt_kind_e   kind_q, kind_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  status_e     err_q, err_d;

  logic        accept;
  logic        have;
  item_kind_e  hit_kind;
  logic [63:0] hit_value;
  logic [2:0]  gossip_lane;
  logic [63:0] gossip_base;
  status_e     final_status;

  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign gossip_lane = 3'(pos_q - GossipIdPos);
  assign gossip_base = (pos_q == GossipIdPos) ? 64'd0 : acc_q;

  always_comb begin
    start_d   = start_q;
    kind_d    = kind_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    err_d     = err_q;
    have      = 1'b0;
    hit_kind  = KIND_END;
    hit_value = 64'd0;

    if (start_q) begin
      start_d = 1'b0;
      pos_d   = 4'd0;
      acc_d   = 64'd0;
      rem_d   = 32'd0;
      if (data_byte_i >= TypeFirst && data_byte_i <= TypeLast) begin
        kind_d = pkt_kind_e'(2'(data_byte_i - TypeFirst));
        err_d  = ST_OK;
      end else begin
        kind_d = PK_DATA;
        err_d  = ST_UNKNOWN;
      end
    end else if (err_q == ST_OK) begin
      if (structure_complete(kind_q, pos_q, rem_q)) begin
        err_d = ST_TRAIL;
      end else begin
        unique case (kind_q)
          PK_DATA: begin
            if (pos_q < DataIdEndPos) begin
              acc_d = acc_q | (64'(data_byte_i) << {pos_q[2:0], 3'b000});
              pos_d = pos_q + 4'd1;
              if (pos_q == IdLastPos) begin
                have      = 1'b1;
                hit_kind  = KIND_MSG_ID;
                hit_value = acc_d;
              end
            end else if (pos_q < DataPayloadPos) begin
              rem_d = rem_q | (32'(data_byte_i) << {pos_q[1:0], 3'b000});
              pos_d = pos_q + 4'd1;
            end else begin
              rem_d     = rem_q - 32'd1;
              have      = 1'b1;
              hit_kind  = KIND_PAYLOAD;
              hit_value = 64'(data_byte_i);
            end
          end
          PK_GOSSIP: begin
            if (pos_q < GossipIdPos) begin
              rem_d = rem_q | (32'(data_byte_i) << {pos_q[1:0], 3'b000});
              pos_d = pos_q + 4'd1;
            end else begin
              acc_d = gossip_base | (64'(data_byte_i) << {gossip_lane, 3'b000});
              if (pos_q == GossipIdLast) begin
                pos_d     = GossipIdPos;
                rem_d     = rem_q - 32'd1;
                have      = 1'b1;
                hit_kind  = KIND_GOSSIP_ID;
                hit_value = acc_d;
              end else begin
                pos_d = pos_q + 4'd1;
              end
            end
          end
          default: begin
            acc_d = acc_q | (64'(data_byte_i) << {pos_q[2:0], 3'b000});
            pos_d = pos_q + 4'd1;
            if (pos_q == IdLastPos) begin
              have      = 1'b1;
              hit_kind  = (kind_q == PK_REQUEST) ? KIND_MSG_ID : KIND_PEER_ID;
              hit_value = acc_d;
            end
          end
        endcase
      end
    end

    // status on the closing byte, judged on the updated layout state
    final_status = err_d;
    if (err_d == ST_OK && !structure_complete(kind_d, pos_d, rem_d)) begin
      final_status = ST_TRUNC;
    end

    result_o.item_kind   = hit_kind;
    result_o.item_value  = hit_value;
    result_o.packet_kind = kind_d;
    result_o.status      = end_of_packet_i ? final_status : ST_OK;
    result_o.final_res   = end_of_packet_i;
    push_o               = accept && (have || end_of_packet_i);

    if (end_of_packet_i) begin
      start_d = 1'b1;
      kind_d  = PK_DATA;
      pos_d   = 4'd0;
      acc_d   = 64'd0;
      rem_d   = 32'd0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      kind_q  <= PK_DATA;
      pos_q   <= 4'd0;
      acc_q   <= 64'd0;
      rem_q   <= 32'd0;
      err_q   <= ST_OK;
    end else if (accept) begin
      start_q <= start_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gpd_queue.sv
// Short result queue between the parsing front end and the output stage.
// Depends on gpd_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module gpd_queue import gpd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire gpd_result_t push_data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             head_valid_o,
  output gpd_result_t      head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  gpd_result_t       entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full result queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty result queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("result queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("result queue count lost a push");
`endif

endmodule

`default_nettype wire

FILE: hdl/gpd_back.sv
// Output stage: drains the result queue into a registered output channel.
// Depends on gpd_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module gpd_back import gpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  wire gpd_result_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output gpd_result_t      out_o
);

  logic        valid_q, valid_d;
  gpd_result_t res_q;

  assign pop_o       = head_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= head_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gossip_packet_decoder_top.sv
// Gossip packet decoder, top level: front end, result queue and output stage.
// Depends on gpd_pkg, gpd_front, gpd_queue and gpd_back.
`timescale 1ns / 1ps
`default_nettype none

// Streaming decoder for gossip datagrams, one byte per transfer with a mark on
// the last byte. The first byte picks the type (1 data, 2 gossip, 3 request,
// 4 heartbeat); multi-byte fields are little-endian. Each completed id and each
// payload byte comes out as a result transfer as soon as it is known, and the
// last byte of a packet always yields a closing result (final_res_o high) with
// the status: ok, unknown type, truncated or trailing bytes. A malformed packet
// is flagged only in that closing result, so items before it are provisional.
// Rate: one byte per clock. The front end parses each byte combinationally;
// each result is registered in a QueueDepth-entry queue and then in the output
// register, so the input keeps taking bytes while results wait and stalls only
// when the queue fills under output back-pressure.
module gossip_packet_decoder_top import gpd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_packet_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       item_kind_o,
  output logic [63:0]      item_value_o,
  output logic [1:0]       packet_kind_o,
  output logic [1:0]       status_o,
  output logic             final_res_o
);

  logic        push;
  gpd_result_t push_data;
  logic        full;
  logic        pop;
  logic        head_valid;
  gpd_result_t head;
  gpd_result_t out_res;

  // Parser: one byte per transfer, emits at most one result per byte
  gpd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .full_i          (full),
    .push_o          (push),
    .result_o        (push_data)
  );

  // Decouples parsing from output back-pressure
  gpd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Registered output, refilled in the cycle its result is taken
  gpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_res)
  );

  assign item_kind_o   = out_res.item_kind;
  assign item_value_o  = out_res.item_value;
  assign packet_kind_o = out_res.packet_kind;
  assign status_o      = out_res.status;
  assign final_res_o   = out_res.final_res;

endmodule

`default_nettype wire
